// File: design/ggpw_pkg.sv
// Shared types, constants, lookup tables and helpers for the Gaussian grid point warp.
package ggpw_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Falloff table
    localparam int GAUSS_DEPTH = 256;
    localparam int IDX_W       = $clog2(GAUSS_DEPTH);
    localparam longint unsigned GAUSS_DEN = 64'(GAUSS_DEPTH - 1);

    // Rotation unit
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [39:0] Q24_MAX = 40'sd8388607;
    localparam logic signed [39:0] Q24_MIN = -40'sd8388608;

    localparam logic [39:0] PI_Q30      = 40'd3373259426;
    localparam logic [39:0] TWO_PI_Q30  = 40'd6746518852;
    localparam logic signed [33:0] PI_S34      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_S34 = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Offset that makes any reachable angle positive before reduction
    localparam logic [39:0] ANGLE_OFS = PI_Q30 + 40'd32 * TWO_PI_Q30;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef enum logic [1:0] {
        KIND_TRANSLATE = 2'd0,
        KIND_SCALE     = 2'd1,
        KIND_ROTATE    = 2'd2,
        KIND_UNDO      = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_SPREAD   = 3'd2,
        REG_KIND     = 3'd3,
        REG_WASH     = 3'd4,
        REG_FLOW     = 3'd5,
        REG_PARAM_A  = 3'd6,
        REG_PARAM_B  = 3'd7
    } reg_idx_t;

    typedef logic [16:0] lam_t;
    typedef lam_t [GAUSS_DEPTH-1:0] gauss_lut_t;

    // Point data that travels down the pipeline with each request
    typedef struct packed {
        logic signed [23:0] cur_x;
        logic signed [23:0] cur_y;
        logic signed [23:0] orig_x;
        logic signed [23:0] orig_y;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic               ok;
        logic signed [23:0] lin_x;
        logic signed [23:0] lin_y;
    } pt_t;

    // Build the falloff table: exp(-4.5 i / (N-1)) as a series squared three times, Q1.16
    function automatic gauss_lut_t build_gauss();
        gauss_lut_t lut;
        longint unsigned t, term, pos, neg, e;
        for (int i = 0; i < GAUSS_DEPTH; i++) begin
            t    = ((64'd9 * 64'(i)) << 26) / GAUSS_DEN;
            term = 64'd1 << 30;
            pos  = term;
            neg  = 64'd0;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * t) >> 30) / 64'(k);
                if (k[0])
                    neg = neg + term;
                else
                    pos = pos + term;
            end
            e = pos - neg;
            for (int k = 0; k < 3; k++)
                e = (e * e + (64'd1 << 29)) >> 30;
            e = (e + (64'd1 << 13)) >> 14;
            lut[i] = (e > 64'd65536) ? 17'd65536 : 17'(e);
        end
        return lut;
    endfunction

    localparam gauss_lut_t GAUSS_LUT = build_gauss();

    // Clamp to the signed 24-bit coordinate range
    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        logic signed [23:0] r;
        if (v > Q24_MAX)
            r = 24'sh7FFFFF;
        else if (v < Q24_MIN)
            r = -24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // One restoring step of the angle reduction modulo two pi
    function automatic logic [39:0] mod_step(input logic [39:0] r, input int b);
        logic [39:0] m;
        m = TWO_PI_Q30 << b;
        return (r >= m) ? (r - m) : r;
    endfunction

endpackage

// File: design/gaussian_grid_point_warp.sv
// Top level of the Gaussian grid point warp: a fully pipelined dab applied to grid points.
//
//  Channel   Handshake          Payload                          Direction
//  input     in_valid/in_stall  cur_x cur_y orig_x orig_y        into block
//  output    out_valid/out_stall new_x new_y moved               out of block
//  config    cfg_we             cfg_index cfg_data               into block
//
// One request per cycle sustained while no result is held back by out_stall; each request
// passes 53 register stages, including the 8-stage table index divider and the 30-stage
// CORDIC rotator.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
// A stall on the output freezes the whole pipeline while a result is offered; in_stall follows it directly.
// Changes of spread reach the square test through spread_reg, the range test through spread_reg and m2_reg.
module gaussian_grid_point_warp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ggpw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ggpw_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ggpw_pkg::COORD_W-1:0]   cur_x,
    input  logic signed [ggpw_pkg::COORD_W-1:0]   cur_y,
    input  logic signed [ggpw_pkg::COORD_W-1:0]   orig_x,
    input  logic signed [ggpw_pkg::COORD_W-1:0]   orig_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ggpw_pkg::COORD_W-1:0]   new_x,
    output logic signed [ggpw_pkg::COORD_W-1:0]   new_y,
    output logic                                  moved
);
    import ggpw_pkg::*;

    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_D  = 3;
    localparam int ST_L  = ST_D + IDX_W;
    localparam int ST_M1 = ST_L + 1;
    localparam int ST_M2 = ST_M1 + 1;
    localparam int ST_M3 = ST_M2 + 1;
    localparam int ST_M4 = ST_M3 + 1;
    localparam int ST_M5 = ST_M4 + 1;
    localparam int ST_M6 = ST_M5 + 1;
    localparam int ST_F  = ST_M6 + 1;
    localparam int ST_R  = ST_F + 1;
    localparam int ST_P1 = ST_R + CORDIC_STEPS;
    localparam int ST_P2 = ST_P1 + 1;
    localparam int ST_W1 = ST_P2 + 1;
    localparam int ST_W2 = ST_W1 + 1;
    localparam int N_ST  = ST_W2 + 1;
    localparam int REM_W = 44 + IDX_W + 1;

    // Configuration registers
    logic signed [23:0] center_x_reg, center_y_reg, param_a_reg, param_b_reg;
    logic [19:0]        spread_reg;
    kind_t              kind_reg;
    logic               wash_reg;
    logic [16:0]        flow_reg;
    logic [43:0]        m2_reg;

    // Pipeline control and point data
    logic              adv;
    logic [N_ST-1:0]   vld_reg;
    pt_t               pipe_reg [ST_W1+1];

    // Stage data
    logic [19:0]        spread_eff;
    logic [21:0]        maxd;
    logic signed [25:0] maxd_s;
    logic               wash;
    pt_t                pt_a;
    pt_t                pt_c_nx, pt_m4_nx;
    logic signed [24:0] ex_a, ey_a;
    logic               sq_a;
    logic signed [49:0] sqx_b, sqy_b;
    logic [48:0]        sqx_reg, sqy_reg;
    logic [49:0]        d2_c;
    logic               in_rng_c;
    logic [REM_W-1:0]   n_c, n_reg;
    logic [REM_W-1:0]   rem_nx [IDX_W];
    logic [REM_W-1:0]   rem_reg [IDX_W];
    logic [IDX_W-1:0]   qb_nx [IDX_W];
    logic [IDX_W-1:0]   qb_reg [IDX_W];
    logic [REM_W-1:0]   rin, dv;
    logic [IDX_W-1:0]   qin;
    lam_t               lam_reg;
    logic signed [41:0] pa_m, pb_m, pa_reg, pb_reg, par, pbr;
    logic signed [25:0] ka_reg, kb_reg;
    logic signed [24:0] ux_reg, uy_reg, ux_nx, uy_nx;
    logic signed [50:0] prx_m, pry_m, prx_reg, pry_reg, prxr, pryr;
    logic signed [26:0] tr_x_nx, tr_y_nx, tr_x_reg, tr_y_reg;
    logic signed [39:0] ka40;
    logic [39:0]        v_nx, v_reg, md4_nx, md4_reg, md5_nx, md5_reg, md6;
    logic signed [33:0] ang_nx, ang_reg;
    logic signed [23:0] base_x, base_y, lin_x_nx, lin_y_nx;
    logic signed [33:0] zf_nx, zf_reg;
    logic               flf_nx, flf_reg;
    logic signed [33:0] cx_nx [CORDIC_STEPS];
    logic signed [33:0] cy_nx [CORDIC_STEPS];
    logic signed [33:0] cz_nx [CORDIC_STEPS];
    logic signed [33:0] cx_reg [CORDIC_STEPS];
    logic signed [33:0] cy_reg [CORDIC_STEPS];
    logic signed [33:0] cz_reg [CORDIC_STEPS];
    logic               cf_reg [CORDIC_STEPS];
    logic signed [33:0] xi, yi, zi, cval, sval;
    logic               fi;
    logic signed [31:0] c32, s32;
    logic signed [56:0] cdx_m, sdy_m, cdy_m, sdx_m;
    logic signed [56:0] cdx_reg, sdy_reg, cdy_reg, sdx_reg;
    logic signed [57:0] sum_x, sum_y;
    logic signed [23:0] r_x_nx, r_y_nx, r_x_reg, r_y_reg, rw_x_reg, rw_y_reg;
    logic signed [24:0] ax_w, ay_w, bx_w, by_w, fdx_w, fdy_w;
    logic signed [49:0] ax2_w, ay2_w, bx2_w, by2_w;
    logic [48:0]        ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic signed [42:0] fx_w, fy_w, fx_reg, fy_reg, fxr, fyr;
    logic [49:0]        lhs, rhs;
    logic signed [23:0] fnx, fny, out_x_nx, out_y_nx;
    logic signed [23:0] new_x_reg, new_y_reg;
    logic               moved_reg;

    // Advance everything unless a finished result is held back
    assign adv       = !(vld_reg[N_ST-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[N_ST-1];
    assign new_x     = new_x_reg;
    assign new_y     = new_y_reg;
    assign moved     = moved_reg;

    // Brush radius limits
    assign spread_eff = (spread_reg == 20'd0) ? 20'd1 : spread_reg;
    assign maxd       = 22'(spread_eff) * 22'd3;
    assign maxd_s     = $signed({4'b0000, maxd});
    assign wash       = wash_reg && (kind_reg != KIND_UNDO);

    // Configuration writes and derived radius square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            spread_reg   <= 20'd256;
            kind_reg     <= KIND_TRANSLATE;
            wash_reg     <= 1'b0;
            flow_reg     <= 17'd65536;
            param_a_reg  <= '0;
            param_b_reg  <= '0;
            m2_reg       <= 44'd589824;
        end
        else
        begin
            m2_reg <= 44'(maxd) * 44'(maxd);
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_CENTER_X: center_x_reg <= $signed(cfg_data);
                    REG_CENTER_Y: center_y_reg <= $signed(cfg_data);
                    REG_SPREAD:   spread_reg   <= cfg_data[19:0];
                    REG_KIND:     kind_reg     <= kind_t'(cfg_data[1:0]);
                    REG_WASH:     wash_reg     <= cfg_data[0];
                    REG_FLOW:     flow_reg     <= cfg_data[16:0];
                    REG_PARAM_A:  param_a_reg  <= $signed(cfg_data);
                    REG_PARAM_B:  param_b_reg  <= $signed(cfg_data);
                    default:      ;
                endcase
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[N_ST-2:0], in_valid};
    end

    // Stage A: distance point, offsets and square test
    always_comb
    begin
        pt_a.cur_x  = cur_x;
        pt_a.cur_y  = cur_y;
        pt_a.orig_x = orig_x;
        pt_a.orig_y = orig_y;
        pt_a.px     = wash ? orig_x : cur_x;
        pt_a.py     = wash ? orig_y : cur_y;
        pt_a.dx     = 25'(pt_a.px) - 25'(center_x_reg);
        pt_a.dy     = 25'(pt_a.py) - 25'(center_y_reg);
        ex_a        = 25'(cur_x) - 25'(center_x_reg);
        ey_a        = 25'(cur_y) - 25'(center_y_reg);
        sq_a        = (26'(ex_a) <= maxd_s) && (26'(ex_a) >= -maxd_s) &&
                      (26'(ey_a) <= maxd_s) && (26'(ey_a) >= -maxd_s);
        pt_a.ok     = sq_a;
        pt_a.lin_x  = cur_x;
        pt_a.lin_y  = cur_y;
    end

    // Stages B and C: squared distance, range test, divider numerator
    always_comb
    begin
        sqx_b    = pipe_reg[ST_A].dx * pipe_reg[ST_A].dx;
        sqy_b    = pipe_reg[ST_A].dy * pipe_reg[ST_A].dy;
        d2_c     = 50'(sqx_reg) + 50'(sqy_reg);
        in_rng_c = d2_c <= 50'(m2_reg);
        n_c      = in_rng_c ? (REM_W'(d2_c[43:0]) * REM_W'(GAUSS_DEPTH - 1)
                               + REM_W'(m2_reg >> 1)) : '0;
        pt_c_nx    = pipe_reg[ST_B];
        pt_c_nx.ok = pipe_reg[ST_B].ok && in_rng_c;
    end

    // Stages D: one quotient bit per stage
    always_comb
    begin
        rin = '0;
        dv  = '0;
        qin = '0;
        for (int j = 0; j < IDX_W; j++)
        begin
            rin = (j == 0) ? n_reg : rem_reg[(j == 0) ? 0 : j - 1];
            qin = (j == 0) ? '0 : qb_reg[(j == 0) ? 0 : j - 1];
            dv  = REM_W'(m2_reg) << (IDX_W - 1 - j);
            rem_nx[j] = rin;
            qb_nx[j]  = qin;
            if (rin >= dv)
            begin
                rem_nx[j] = rin - dv;
                qb_nx[j][IDX_W-1-j] = 1'b1;
            end
        end
    end

    // Stages M: lambda products, kind operands, linear results, angle reduction
    always_comb
    begin
        pa_m    = $signed({1'b0, lam_reg}) * param_a_reg;
        pb_m    = $signed({1'b0, lam_reg}) * param_b_reg;
        par     = pa_reg + 42'sd32768;
        pbr     = pb_reg + 42'sd32768;
        ux_nx   = (kind_reg == KIND_UNDO) ?
                  (25'(pipe_reg[ST_M1].orig_x) - 25'(pipe_reg[ST_M1].cur_x)) :
                  pipe_reg[ST_M1].dx;
        uy_nx   = (kind_reg == KIND_UNDO) ?
                  (25'(pipe_reg[ST_M1].orig_y) - 25'(pipe_reg[ST_M1].cur_y)) :
                  pipe_reg[ST_M1].dy;
        prx_m   = ux_reg * ka_reg;
        pry_m   = uy_reg * ka_reg;
        tr_x_nx = 27'(pipe_reg[ST_M2].px) + 27'(ka_reg);
        tr_y_nx = 27'(pipe_reg[ST_M2].py) + 27'(kb_reg);
        ka40    = 40'(ka_reg);
        v_nx    = $unsigned(ka40 <<< 14) + ANGLE_OFS;

        prxr    = prx_reg + 51'sd32768;
        pryr    = pry_reg + 51'sd32768;
        base_x  = (kind_reg == KIND_SCALE) ? pipe_reg[ST_M3].px : pipe_reg[ST_M3].cur_x;
        base_y  = (kind_reg == KIND_SCALE) ? pipe_reg[ST_M3].py : pipe_reg[ST_M3].cur_y;
        if (kind_reg == KIND_TRANSLATE)
        begin
            lin_x_nx = sat24(40'(tr_x_reg));
            lin_y_nx = sat24(40'(tr_y_reg));
        end
        else
        begin
            lin_x_nx = sat24(40'($signed(prxr[50:16])) + 40'(base_x));
            lin_y_nx = sat24(40'($signed(pryr[50:16])) + 40'(base_y));
        end
        pt_m4_nx       = pipe_reg[ST_M3];
        pt_m4_nx.lin_x = lin_x_nx;
        pt_m4_nx.lin_y = lin_y_nx;

        md4_nx = mod_step(mod_step(v_reg, 5), 4);
        md5_nx = mod_step(mod_step(md4_reg, 3), 2);
        md6    = mod_step(mod_step(md5_reg, 1), 0);
        ang_nx = $signed(34'(md6)) - PI_S34;

        // Fold into the right half plane
        if (ang_reg > HALF_PI_S34)
        begin
            zf_nx  = ang_reg - PI_S34;
            flf_nx = 1'b1;
        end
        else if (ang_reg < -HALF_PI_S34)
        begin
            zf_nx  = ang_reg + PI_S34;
            flf_nx = 1'b1;
        end
        else
        begin
            zf_nx  = ang_reg;
            flf_nx = 1'b0;
        end
    end

    // Stages R: one CORDIC iteration per stage
    always_comb
    begin
        xi = '0;
        yi = '0;
        zi = '0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xi = (i == 0) ? CORDIC_GAIN : cx_reg[(i == 0) ? 0 : i - 1];
            yi = (i == 0) ? 34'sd0 : cy_reg[(i == 0) ? 0 : i - 1];
            zi = (i == 0) ? zf_reg : cz_reg[(i == 0) ? 0 : i - 1];
            if (zi >= 34'sd0)
            begin
                cx_nx[i] = xi - (yi >>> i);
                cy_nx[i] = yi + (xi >>> i);
                cz_nx[i] = zi - $signed({2'b00, ATAN_Q30[i]});
            end
            else
            begin
                cx_nx[i] = xi + (yi >>> i);
                cy_nx[i] = yi - (xi >>> i);
                cz_nx[i] = zi + $signed({2'b00, ATAN_Q30[i]});
            end
        end
    end

    // Stages P: rotate about the centre, pick the kind's result
    always_comb
    begin
        fi     = cf_reg[CORDIC_STEPS-1];
        cval   = fi ? -cx_reg[CORDIC_STEPS-1] : cx_reg[CORDIC_STEPS-1];
        sval   = fi ? -cy_reg[CORDIC_STEPS-1] : cy_reg[CORDIC_STEPS-1];
        c32    = 32'(cval);
        s32    = 32'(sval);
        cdx_m  = c32 * pipe_reg[ST_P1-1].dx;
        sdy_m  = s32 * pipe_reg[ST_P1-1].dy;
        cdy_m  = c32 * pipe_reg[ST_P1-1].dy;
        sdx_m  = s32 * pipe_reg[ST_P1-1].dx;
        sum_x  = 58'(cdx_reg) + 58'(sdy_reg) + 58'sd536870912;
        sum_y  = 58'(cdy_reg) - 58'(sdx_reg) + 58'sd536870912;
        if (kind_reg == KIND_ROTATE)
        begin
            r_x_nx = sat24(40'($signed(sum_x[57:30])) + 40'(center_x_reg));
            r_y_nx = sat24(40'($signed(sum_y[57:30])) + 40'(center_y_reg));
        end
        else
        begin
            r_x_nx = pipe_reg[ST_P1].lin_x;
            r_y_nx = pipe_reg[ST_P1].lin_y;
        end
    end

    // Stages W: wash test and flow blend, final selection
    always_comb
    begin
        ax_w  = 25'(r_x_reg) - 25'(pipe_reg[ST_P2].orig_x);
        ay_w  = 25'(r_y_reg) - 25'(pipe_reg[ST_P2].orig_y);
        bx_w  = 25'(pipe_reg[ST_P2].cur_x) - 25'(pipe_reg[ST_P2].orig_x);
        by_w  = 25'(pipe_reg[ST_P2].cur_y) - 25'(pipe_reg[ST_P2].orig_y);
        ax2_w = ax_w * ax_w;
        ay2_w = ay_w * ay_w;
        bx2_w = bx_w * bx_w;
        by2_w = by_w * by_w;
        fdx_w = 25'(r_x_reg) - 25'(pipe_reg[ST_P2].cur_x);
        fdy_w = 25'(r_y_reg) - 25'(pipe_reg[ST_P2].cur_y);
        fx_w  = $signed({1'b0, flow_reg}) * fdx_w;
        fy_w  = $signed({1'b0, flow_reg}) * fdy_w;

        lhs   = 50'(ax2_reg) + 50'(ay2_reg);
        rhs   = 50'(bx2_reg) + 50'(by2_reg);
        fxr   = fx_reg + 43'sd32768;
        fyr   = fy_reg + 43'sd32768;
        fnx   = sat24(40'($signed(fxr[42:16])) + 40'(pipe_reg[ST_W1].cur_x));
        fny   = sat24(40'($signed(fyr[42:16])) + 40'(pipe_reg[ST_W1].cur_y));
        if (!pipe_reg[ST_W1].ok)
        begin
            out_x_nx = pipe_reg[ST_W1].cur_x;
            out_y_nx = pipe_reg[ST_W1].cur_y;
        end
        else if (!wash)
        begin
            out_x_nx = rw_x_reg;
            out_y_nx = rw_y_reg;
        end
        else if (lhs > rhs)
        begin
            out_x_nx = fnx;
            out_y_nx = fny;
        end
        else
        begin
            out_x_nx = pipe_reg[ST_W1].cur_x;
            out_y_nx = pipe_reg[ST_W1].cur_y;
        end
    end

    // Advance all stage registers together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= pt_a;
            for (int s = 1; s <= ST_W1; s++)
            begin
                if (s == ST_C)
                    pipe_reg[s] <= pt_c_nx;
                else if (s == ST_M4)
                    pipe_reg[s] <= pt_m4_nx;
                else
                    pipe_reg[s] <= pipe_reg[s-1];
            end

            sqx_reg <= 49'(sqx_b);
            sqy_reg <= 49'(sqy_b);
            n_reg   <= n_c;
            for (int j = 0; j < IDX_W; j++)
            begin
                rem_reg[j] <= rem_nx[j];
                qb_reg[j]  <= qb_nx[j];
            end
            lam_reg  <= GAUSS_LUT[qb_reg[IDX_W-1]];
            pa_reg   <= pa_m;
            pb_reg   <= pb_m;
            ka_reg   <= par[41:16];
            kb_reg   <= pbr[41:16];
            ux_reg   <= ux_nx;
            uy_reg   <= uy_nx;
            prx_reg  <= prx_m;
            pry_reg  <= pry_m;
            tr_x_reg <= tr_x_nx;
            tr_y_reg <= tr_y_nx;
            v_reg    <= v_nx;
            md4_reg  <= md4_nx;
            md5_reg  <= md5_nx;
            ang_reg  <= ang_nx;
            zf_reg   <= zf_nx;
            flf_reg  <= flf_nx;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                cx_reg[i] <= cx_nx[i];
                cy_reg[i] <= cy_nx[i];
                cz_reg[i] <= cz_nx[i];
                cf_reg[i] <= (i == 0) ? flf_reg : cf_reg[(i == 0) ? 0 : i - 1];
            end
            cdx_reg  <= cdx_m;
            sdy_reg  <= sdy_m;
            cdy_reg  <= cdy_m;
            sdx_reg  <= sdx_m;
            r_x_reg  <= r_x_nx;
            r_y_reg  <= r_y_nx;
            rw_x_reg <= r_x_reg;
            rw_y_reg <= r_y_reg;
            ax2_reg  <= 49'(ax2_w);
            ay2_reg  <= 49'(ay2_w);
            bx2_reg  <= 49'(bx2_w);
            by2_reg  <= 49'(by2_w);
            fx_reg   <= fx_w;
            fy_reg   <= fy_w;
            new_x_reg <= out_x_nx;
            new_y_reg <= out_y_nx;
            moved_reg <= (out_x_nx != pipe_reg[ST_W1].cur_x) ||
                         (out_y_nx != pipe_reg[ST_W1].cur_y);
        end
    end

endmodule

// File: design/ggpw_checker.sv
// Port-level checks for the Gaussian grid point warp, bound to the top level.
module ggpw_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [ggpw_pkg::COORD_W-1:0] new_x,
    input logic signed [ggpw_pkg::COORD_W-1:0] new_y,
    input logic                                moved
);
    import ggpw_pkg::*;

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(new_x) && $stable(new_y) && $stable(moved))
        else $error("result changed while stalled");

    // Input backs up only behind a blocked result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input request stalled without output backpressure");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind gaussian_grid_point_warp ggpw_checker u_ggpw_checker (.*);
